>>> rtl/animation_blend_phase_controller_core_defines.svh
// assertion helpers for the rtl core
`ifndef ANIMATION_BLEND_PHASE_CONTROLLER_CORE_DEFINES_SVH
`define ANIMATION_BLEND_PHASE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define ABPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("abpc same-cycle check failed");

// next-cycle implication, off during reset
`define ABPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("abpc next-cycle check failed");

`endif

>>> rtl/abpc_pkg.sv
package abpc_pkg;

	localparam int unsigned FRAME_W   = 32;
	localparam int unsigned SPEED_W   = 16;
	localparam int unsigned WEIGHT_W  = 17;
	localparam int unsigned ANIM_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h10000;
	localparam logic [SPEED_W-1:0]  SPEED_RESET = 16'h0100;

	// one quotient bit per step, quotient never exceeds 1.0 in Q1.16
	localparam int unsigned DIV_STEPS = WEIGHT_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		PH_FADEIN   = 2'd0,
		PH_NORMAL   = 2'd1,
		PH_FADEOUT  = 2'd2,
		PH_FINISHED = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		MODE_LOOP = 2'd0,
		MODE_ONCE = 2'd1,
		MODE_BACK = 2'd2,
		MODE_HOLD = 2'd3
	} play_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STOP  = 3'd0,
		CFG_SPEED = 3'd1,
		CFG_BLEND = 3'd2,
		CFG_END   = 3'd3,
		CFG_MODE  = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_LOAD     = 4'd1,
		OP_MUL      = 4'd2,
		OP_ADV      = 4'd3,
		OP_FADEIN   = 4'd4,
		OP_NORMAL   = 4'd5,
		OP_FADEOUT  = 4'd6,
		OP_DIV_STEP = 4'd7,
		OP_DIV_TAKE = 4'd8,
		OP_OUT      = 4'd9
	} dp_op_t;

	typedef struct packed {
		phase_t phase;
		logic   blen_lt_pos;
		logic   blen_zero;
		logic   stopped;
	} abpc_sts_t;

endpackage

>>> rtl/abpc_in_if.sv
interface abpc_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [abpc_pkg::FRAME_W-1:0]           frame_delta;
	logic [abpc_pkg::WEIGHT_W-1:0]          master_weight;
	logic [abpc_pkg::ANIM_W-1:0]            master_animation;

	modport source (output valid, frame_delta, master_weight, master_animation, input ready);
	modport sink (input valid, frame_delta, master_weight, master_animation, output ready);
endinterface

>>> rtl/abpc_out_if.sv
interface abpc_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [abpc_pkg::WEIGHT_W-1:0]          blend_weight;
	logic [1:0]                             phase_now;
	logic [abpc_pkg::FRAME_W-1:0]           frame_position;
	logic                                   end_pulse;
	logic [abpc_pkg::ANIM_W-1:0]            animation_id;

	modport source (output valid, blend_weight, phase_now, frame_position, end_pulse,
		animation_id, input ready);
	modport sink (input valid, blend_weight, phase_now, frame_position, end_pulse,
		animation_id, output ready);
endinterface

>>> rtl/abpc_cfg_if.sv
interface abpc_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [abpc_pkg::CFG_IDX_W-1:0]         index;
	logic [abpc_pkg::CFG_DATA_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/animation_blend_phase_controller_core.sv
// Animation blend phase controller. Each input request is one time tick and yields exactly
// one result request. The tick advances the Q16.16 frame position by delta times the Q8.8
// speed, then walks fade-in, normal and fade-out in order, all in one tick, but it ends
// after fade-in while fade-in holds. A fade-in or fade-out weight comes from a restoring
// divider that produces one quotient bit per cycle; with a zero blend length no weight is
// divided. A stopped or finished tick goes straight to its result. A result held back by
// the sink stalls the block until the output register is free. One tick is worked at a
// time; a new tick is accepted as soon as the previous one has moved its result into the
// output register, even if that result has not yet been taken.
// Configuration writes are always accepted and must be made only while the block is idle.
`include "animation_blend_phase_controller_core_defines.svh"

module animation_blend_phase_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	abpc_in_if.sink     in_ch,
	abpc_out_if.source  out_ch,
	abpc_cfg_if.sink    cfg_ch
);

	// status from datapath to controller
	abpc_pkg::abpc_sts_t  sts;
	// one datapath operation per cycle
	abpc_pkg::dp_op_t     op;
	logic                 cfg_wr;

	// register writes never stall
	assign cfg_ch.ready = 1'b1;
	assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

	// sequencer: walks multiply, advance, the three phases and the divide
	abpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.op        (op)
	);

	// config registers, playback state, multiplier, divider and result register
	abpc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.sts              (sts),
		.frame_delta      (in_ch.frame_delta),
		.master_weight    (in_ch.master_weight),
		.master_animation (in_ch.master_animation),
		.cfg_wr           (cfg_wr),
		.cfg_index        (cfg_ch.index),
		.cfg_data         (cfg_ch.data),
		.blend_weight     (out_ch.blend_weight),
		.phase_now        (out_ch.phase_now),
		.frame_position   (out_ch.frame_position),
		.end_pulse        (out_ch.end_pulse),
		.animation_id     (out_ch.animation_id)
	);

	// end pulse only comes with the finished phase
	`ABPC_ASSERT_IMP(a_pulse_finished, clk, arst_n, out_ch.valid && out_ch.end_pulse, out_ch.phase_now == abpc_pkg::PH_FINISHED)
	// only reset leaves the finished phase
	`ABPC_ASSERT_NEXT(a_finished_sticks, clk, arst_n, sts.phase == abpc_pkg::PH_FINISHED, sts.phase == abpc_pkg::PH_FINISHED)
	// reported weight never exceeds one
	`ABPC_ASSERT_IMP(a_weight_range, clk, arst_n, out_ch.valid, out_ch.blend_weight <= abpc_pkg::WEIGHT_ONE)

endmodule

>>> rtl/abpc_dp.sv
module abpc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  abpc_pkg::dp_op_t                    op,
	output abpc_pkg::abpc_sts_t                 sts,
	input  logic [abpc_pkg::FRAME_W-1:0]        frame_delta,
	input  logic [abpc_pkg::WEIGHT_W-1:0]       master_weight,
	input  logic [abpc_pkg::ANIM_W-1:0]         master_animation,
	input  logic                                cfg_wr,
	input  logic [abpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [abpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [abpc_pkg::WEIGHT_W-1:0]       blend_weight,
	output logic [1:0]                          phase_now,
	output logic [abpc_pkg::FRAME_W-1:0]        frame_position,
	output logic                                end_pulse,
	output logic [abpc_pkg::ANIM_W-1:0]         animation_id
);

	localparam int unsigned PROD_W = abpc_pkg::FRAME_W + abpc_pkg::SPEED_W;
	localparam int unsigned STEP_W = PROD_W - 8;
	localparam int unsigned SUM_W  = STEP_W + 1;
	localparam int unsigned REM_W  = abpc_pkg::FRAME_W + 1;

	// configuration
	logic                               stop_q;
	logic [abpc_pkg::SPEED_W-1:0]       speed_q;
	logic [abpc_pkg::FRAME_W-1:0]       blen_q;
	logic [abpc_pkg::FRAME_W-1:0]       end_q;
	abpc_pkg::play_mode_t               mode_q;

	// block state
	abpc_pkg::phase_t                   phase_q;
	logic [abpc_pkg::FRAME_W-1:0]       pos_q;
	logic [abpc_pkg::WEIGHT_W-1:0]      weight_q;
	logic [abpc_pkg::ANIM_W-1:0]        anim_q;
	logic                               pulse_q;

	// request operands and work registers
	logic [abpc_pkg::FRAME_W-1:0]       delta_q;
	logic [abpc_pkg::WEIGHT_W-1:0]      mweight_q;
	logic [abpc_pkg::ANIM_W-1:0]        manim_q;
	logic [PROD_W-1:0]                  prod_q;
	logic [REM_W-1:0]                   rem_q;
	logic [abpc_pkg::WEIGHT_W-1:0]      quo_q;

	logic [SUM_W-1:0]                   sum;
	logic [abpc_pkg::FRAME_W-1:0]       pos_adv;
	logic                               blen_lt_pos;
	logic                               end_le_pos;
	logic [abpc_pkg::FRAME_W-1:0]       fade_diff;
	logic [abpc_pkg::WEIGHT_W-1:0]      mweight_sat;
	logic [abpc_pkg::FRAME_W-1:0]       pos_back;
	logic                               div_ge;
	logic [REM_W-1:0]                   rem_sub;

	assign sum = {{(SUM_W - abpc_pkg::FRAME_W){1'b0}}, pos_q}
		+ {1'b0, prod_q[PROD_W-1:8]};
	assign pos_adv = (sum[SUM_W-1:abpc_pkg::FRAME_W] != '0) ? '1
		: sum[abpc_pkg::FRAME_W-1:0];

	assign blen_lt_pos = blen_q < pos_q;
	assign end_le_pos  = end_q <= pos_q;
	assign fade_diff   = blen_q - pos_q;
	assign mweight_sat = (mweight_q > abpc_pkg::WEIGHT_ONE) ? abpc_pkg::WEIGHT_ONE : mweight_q;
	assign pos_back    = (pos_q > delta_q) ? pos_q - delta_q : '0;

	assign div_ge  = rem_q >= {1'b0, blen_q};
	assign rem_sub = div_ge ? rem_q - {1'b0, blen_q} : rem_q;

	assign sts.phase       = phase_q;
	assign sts.blen_lt_pos = blen_lt_pos;
	assign sts.blen_zero   = (blen_q == '0);
	assign sts.stopped     = stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q   <= 1'b0;
			speed_q  <= abpc_pkg::SPEED_RESET;
			blen_q   <= '0;
			end_q    <= '0;
			mode_q   <= abpc_pkg::MODE_LOOP;
			phase_q  <= abpc_pkg::PH_FADEIN;
			pos_q    <= '0;
			weight_q <= '0;
			anim_q   <= '0;
			pulse_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					abpc_pkg::CFG_STOP:  stop_q  <= cfg_data[0];
					abpc_pkg::CFG_SPEED: speed_q <= cfg_data[abpc_pkg::SPEED_W-1:0];
					abpc_pkg::CFG_BLEND: blen_q  <= cfg_data;
					abpc_pkg::CFG_END:   end_q   <= cfg_data;
					abpc_pkg::CFG_MODE:  mode_q  <= abpc_pkg::play_mode_t'(cfg_data[1:0]);
					default: ;
				endcase
			end
			case (op)
				abpc_pkg::OP_LOAD: pulse_q <= 1'b0;
				abpc_pkg::OP_ADV:  pos_q <= pos_adv;
				abpc_pkg::OP_FADEIN: begin
					if (phase_q == abpc_pkg::PH_FADEIN) begin
						weight_q <= '0;
						if (blen_lt_pos) begin
							phase_q <= abpc_pkg::PH_NORMAL;
							pos_q   <= pos_q - blen_q;
						end
					end
				end
				abpc_pkg::OP_NORMAL: begin
					if (phase_q == abpc_pkg::PH_NORMAL) begin
						weight_q <= mweight_sat;
						if (end_le_pos) begin
							case (mode_q)
								abpc_pkg::MODE_LOOP: pos_q <= '0;
								abpc_pkg::MODE_ONCE: begin
									pos_q   <= '0;
									phase_q <= abpc_pkg::PH_FADEOUT;
								end
								abpc_pkg::MODE_BACK: pos_q <= pos_back;
								default: pos_q <= end_q;
							endcase
						end
					end
				end
				abpc_pkg::OP_FADEOUT: begin
					if (phase_q == abpc_pkg::PH_FADEOUT) begin
						anim_q <= manim_q;
						if (blen_lt_pos) begin
							phase_q <= abpc_pkg::PH_FINISHED;
							pulse_q <= 1'b1;
						end else if (blen_q == '0) begin
							weight_q <= abpc_pkg::WEIGHT_ONE;
						end
					end
				end
				abpc_pkg::OP_DIV_TAKE: weight_q <= quo_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			abpc_pkg::OP_LOAD: begin
				delta_q   <= frame_delta;
				mweight_q <= master_weight;
				manim_q   <= master_animation;
			end
			abpc_pkg::OP_MUL: prod_q <= PROD_W'(delta_q) * PROD_W'(speed_q);
			abpc_pkg::OP_FADEIN, abpc_pkg::OP_FADEOUT: begin
				// restoring divide of (blen - pos) << 16 by blen
				rem_q <= {1'b0, fade_diff};
				quo_q <= '0;
			end
			abpc_pkg::OP_DIV_STEP: begin
				rem_q <= {rem_sub[REM_W-2:0], 1'b0};
				quo_q <= {quo_q[abpc_pkg::WEIGHT_W-2:0], div_ge};
			end
			abpc_pkg::OP_OUT: begin
				blend_weight   <= weight_q;
				phase_now      <= phase_q;
				frame_position <= pos_q;
				end_pulse      <= pulse_q;
				animation_id   <= anim_q;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/abpc_ctrl.sv
module abpc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  abpc_pkg::abpc_sts_t         sts,
	output abpc_pkg::dp_op_t            op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ADV,
		S_FADEIN,
		S_NORMAL,
		S_FADEOUT,
		S_DIV,
		S_TAKE,
		S_DONE
	} state_t;

	state_t                             state_q;
	logic [abpc_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                               out_valid_q;
	logic                               out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		case (state_q)
			S_IDLE:    op = in_valid ? abpc_pkg::OP_LOAD : abpc_pkg::OP_NONE;
			S_MUL:     op = abpc_pkg::OP_MUL;
			S_ADV:     op = abpc_pkg::OP_ADV;
			S_FADEIN:  op = abpc_pkg::OP_FADEIN;
			S_NORMAL:  op = abpc_pkg::OP_NORMAL;
			S_FADEOUT: op = abpc_pkg::OP_FADEOUT;
			S_DIV:     op = abpc_pkg::OP_DIV_STEP;
			S_TAKE:    op = abpc_pkg::OP_DIV_TAKE;
			S_DONE:    op = out_free ? abpc_pkg::OP_OUT : abpc_pkg::OP_NONE;
			default:   op = abpc_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one being taken, otherwise a taken result clears
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						// stopped or finished ticks only report
						if (sts.stopped || sts.phase == abpc_pkg::PH_FINISHED) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: state_q <= S_ADV;
				S_ADV: state_q <= S_FADEIN;
				S_FADEIN: begin
					cnt_q <= '0;
					if (sts.phase != abpc_pkg::PH_FADEIN || sts.blen_lt_pos) begin
						state_q <= S_NORMAL;
					end else if (!sts.blen_zero) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_NORMAL: state_q <= S_FADEOUT;
				S_FADEOUT: begin
					cnt_q <= '0;
					if (sts.phase == abpc_pkg::PH_FADEOUT && !sts.blen_lt_pos && !sts.blen_zero) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == abpc_pkg::DIV_CNT_W'(abpc_pkg::DIV_STEPS - 1)) begin
						state_q <= S_TAKE;
					end
				end
				S_TAKE: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
